/* rtl/core/lcsg_pkg.sv */
package lcsg_pkg;

  localparam int FREQ_W      = 31;
  localparam int HALF_W      = 30;
  localparam int CFG_W       = 32;
  localparam int AMP_W       = 15;
  localparam int DC_W        = 16;
  localparam int SAMPLE_W    = 16;
  localparam int CFG_ADDR_W  = 3;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [63:0] PIH_Q48 = 64'h0001_921F_B544_42D1;
  localparam logic [63:0] Q30_ONE = 64'd1 << 30;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_START_FREQ = 3'd0,
    CFG_HALF_STEP  = 3'd1,
    CFG_SWEEP_LEN  = 3'd2,
    CFG_PHASE_OFS  = 3'd3,
    CFG_AMPLITUDE  = 3'd4,
    CFG_DC_OFFSET  = 3'd5,
    CFG_INIT_DELAY = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic        [FREQ_W-1:0] start_freq;
    logic signed [HALF_W-1:0] half_step;
    logic        [CFG_W-1:0]  sweep_len;
    logic        [CFG_W-1:0]  phase_offset;
    logic        [AMP_W-1:0]  amplitude;
    logic signed [DC_W-1:0]   dc_offset;
    logic        [CFG_W-1:0]  initial_delay;
  } lcsg_cfg_t;

  typedef struct packed {
    logic              delay;
    logic [FREQ_W-1:0] freq;
  } lcsg_ctl_t;

  // quarter-wave sine entry, eight-term Taylor series in Q30
  function automatic logic [31:0] sine_entry(input int unsigned i, input int addr_bits,
                                             input int sample_bits);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] e;
    logic [63:0] tmax;
    int          sh;
    sh   = addr_bits + 19;
    tmax = (64'd1 << (sample_bits - 1)) - 64'd1;
    x    = (PIH_Q48 * (64'(2 * i) + 64'd1) + (64'd1 << (sh - 1))) >> sh;
    x2   = (x * x) >> 30;
    t    = Q30_ONE;
    t    = Q30_ONE - (((x2 * t) >> 30) / 64'd210);
    t    = Q30_ONE - (((x2 * t) >> 30) / 64'd156);
    t    = Q30_ONE - (((x2 * t) >> 30) / 64'd110);
    t    = Q30_ONE - (((x2 * t) >> 30) / 64'd72);
    t    = Q30_ONE - (((x2 * t) >> 30) / 64'd42);
    t    = Q30_ONE - (((x2 * t) >> 30) / 64'd20);
    t    = Q30_ONE - (((x2 * t) >> 30) / 64'd6);
    s    = (x * t) >> 30;
    e    = (s * tmax + (64'd1 << 29)) >> 30;
    if (e > tmax) begin
      e = tmax;
    end
    return 32'(e);
  endfunction

endpackage

/* rtl/core/lcsg_front.sv */
module lcsg_front import lcsg_pkg::*; #(
  parameter int PHASE_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  take,
  input  logic                  tick,
  input  lcsg_cfg_t             cfg,
  output logic                  wr_en,
  output lcsg_ctl_t             wr_ctl,
  output logic [PHASE_BITS-1:0] wr_phase
);

  localparam logic [63:0] FREQ_LIMIT =
    (PHASE_BITS - 2 < 30) ? (64'd1 << (PHASE_BITS - 2)) : (64'd1 << 30);

  logic [31:0]           delay_count_r, delay_count_nxt;
  logic [31:0]           period_pos_r, period_pos_nxt;
  logic [PHASE_BITS-1:0] phase_acc_r, phase_acc_nxt;
  logic [PHASE_BITS-1:0] freq_acc_r, freq_acc_nxt;
  logic [PHASE_BITS-1:0] ph, fr, half;
  logic [63:0]           fr_wide, half_wide;
  logic [32:0]           len, pos_inc;
  logic                  in_dly, restart;

  always_comb begin
    in_dly          = (cfg.initial_delay != '0) && (delay_count_r < cfg.initial_delay);
    delay_count_nxt = delay_count_r + 32'd1;
    len             = (cfg.sweep_len == '0) ? 33'd1 : {1'b0, cfg.sweep_len};
    restart         = (period_pos_r == '0);
    ph              = restart ? PHASE_BITS'(cfg.phase_offset) : phase_acc_r;
    fr              = restart ? PHASE_BITS'(cfg.start_freq) : freq_acc_r;
    half_wide       = {{(64 - HALF_W){cfg.half_step[HALF_W-1]}}, cfg.half_step};
    half            = PHASE_BITS'(half_wide);
    phase_acc_nxt   = ph + fr + half;
    freq_acc_nxt    = fr + {half[PHASE_BITS-2:0], 1'b0};
    pos_inc         = {1'b0, period_pos_r} + 33'd1;
    period_pos_nxt  = (pos_inc >= len) ? '0 : pos_inc[31:0];
    fr_wide         = 64'(fr);

    wr_en        = take && tick;
    wr_phase     = ph;
    wr_ctl.delay = in_dly;
    if (in_dly || fr[PHASE_BITS-1]) begin
      wr_ctl.freq = '0;
    end else if (fr_wide > FREQ_LIMIT) begin
      wr_ctl.freq = FREQ_W'(FREQ_LIMIT);
    end else begin
      wr_ctl.freq = FREQ_W'(fr_wide);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_count_r <= '0;
      period_pos_r  <= '0;
      phase_acc_r   <= '0;
      freq_acc_r    <= '0;
    end else if (wr_en) begin
      if (in_dly) begin
        delay_count_r <= delay_count_nxt;
      end else begin
        period_pos_r <= period_pos_nxt;
        phase_acc_r  <= phase_acc_nxt;
        freq_acc_r   <= freq_acc_nxt;
      end
    end
  end

endmodule

/* rtl/core/lcsg_queue.sv */
module lcsg_queue import lcsg_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             full,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_wr, do_rd;

  always_comb begin
    full       = (count_r == CW'(DEPTH));
    empty      = (count_r == '0);
    do_wr      = wr_en && !full;
    do_rd      = rd_en && !empty;
    wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    count_nxt  = count_r + CW'(do_wr) - CW'(do_rd);
    rd_data    = mem_r[rd_ptr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_wr) begin
        wr_ptr_r <= wr_ptr_nxt;
      end
      if (do_rd) begin
        rd_ptr_r <= rd_ptr_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

/* rtl/core/lcsg_back.sv */
module lcsg_back import lcsg_pkg::*; #(
  parameter int PHASE_BITS    = 32,
  parameter int LUT_ADDR_BITS = 10,
  parameter int SAMPLE_BITS   = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_empty,
  input  lcsg_ctl_t             q_ctl,
  input  logic [PHASE_BITS-1:0] q_phase,
  output logic                  q_pop,
  input  lcsg_cfg_t             cfg,
  input  logic                  pop,
  output logic                  empty,
  output logic [SAMPLE_W-1:0]   sample,
  output logic [FREQ_W-1:0]     freq_word,
  output logic                  in_delay
);

  localparam int LUT_SIZE  = 2 ** LUT_ADDR_BITS;
  localparam int MAG_BITS  = SAMPLE_BITS - 1;
  localparam int PROD_BITS = MAG_BITS + AMP_W;
  localparam int OUT_BITS  = PROD_BITS - MAG_BITS + 1;
  localparam logic signed [SAMPLE_W+1:0] SAT_MAX = (SAMPLE_W + 2)'((1 << (SAMPLE_W - 1)) - 1);
  localparam logic signed [SAMPLE_W+1:0] SAT_MIN = -SAT_MAX - (SAMPLE_W + 2)'(1);

  logic [MAG_BITS-1:0]      sine_tab [LUT_SIZE];
  logic [1:0]               quad;
  logic [LUT_ADDR_BITS-1:0] idx, addr;
  logic                     adv;

  logic                     v1_r, v2_r, v3_r;
  lcsg_ctl_t                ctl1_r, ctl2_r;
  logic                     neg1_r, neg2_r;
  logic [MAG_BITS-1:0]      tab1_r;
  logic [PROD_BITS-1:0]     prod2_r;
  logic [SAMPLE_W-1:0]      sample3_r, sample_nxt;
  logic [FREQ_W-1:0]        freq3_r;
  logic                     dly3_r;

  logic [PROD_BITS:0]          rnd;
  logic [OUT_BITS-1:0]         mag;
  logic signed [SAMPLE_W+1:0]  smag, sum;

  for (genvar g = 0; g < LUT_SIZE; g++) begin : g_tab
    assign sine_tab[g] = MAG_BITS'(sine_entry(g, LUT_ADDR_BITS, SAMPLE_BITS));
  end

  always_comb begin
    adv   = !v3_r || pop;
    q_pop = adv && !q_empty;
    quad  = q_phase[PHASE_BITS-1 -: 2];
    idx   = q_phase[PHASE_BITS-3 -: LUT_ADDR_BITS];
    addr  = quad[0] ? ~idx : idx;

    rnd  = {1'b0, prod2_r} + (PROD_BITS + 1)'(1 << (SAMPLE_BITS - 2));
    mag  = rnd[PROD_BITS:MAG_BITS];
    smag = signed'((SAMPLE_W + 2)'(mag));
    sum  = (neg2_r ? -smag : smag) + {{2{cfg.dc_offset[DC_W-1]}}, cfg.dc_offset};
    if (ctl2_r.delay) begin
      sample_nxt = '0;
    end else if (sum > SAT_MAX) begin
      sample_nxt = SAT_MAX[SAMPLE_W-1:0];
    end else if (sum < SAT_MIN) begin
      sample_nxt = SAT_MIN[SAMPLE_W-1:0];
    end else begin
      sample_nxt = sum[SAMPLE_W-1:0];
    end

    empty     = !v3_r;
    sample    = sample3_r;
    freq_word = freq3_r;
    in_delay  = dly3_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (adv) begin
      v1_r <= q_pop;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctl1_r    <= q_ctl;
      neg1_r    <= quad[1];
      tab1_r    <= sine_tab[addr];
      ctl2_r    <= ctl1_r;
      neg2_r    <= neg1_r;
      prod2_r   <= PROD_BITS'(tab1_r * cfg.amplitude);
      sample3_r <= sample_nxt;
      freq3_r   <= ctl2_r.freq;
      dly3_r    <= ctl2_r.delay;
    end
  end

endmodule

/* rtl/core/linear_chirp_sine_generator.sv */
// Channel   Handshake     Payload
// input     push / full   in_tick
// result    empty / pop   out_sample, out_freq_word, out_in_delay
// config    cfg_we        cfg_addr, cfg_wdata
//
// One word per clock sustained while pop keeps up and full stays low.
// The front updates the sweep accumulators in the cycle of acceptance; the back runs
// sine table read, amplitude multiply and rounding/saturation as three stages.
// Reset clears counters, accumulators, queue and pipeline; config returns to defaults.
// With pop low the back holds; the 4-entry queue fills and full rises.
// A tick of zero is taken and makes no result.
module linear_chirp_sine_generator import lcsg_pkg::*; #(
  parameter int PHASE_BITS    = 32,
  parameter int LUT_ADDR_BITS = 10,
  parameter int SAMPLE_BITS   = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  output logic                  full,
  input  logic                  in_tick,
  output logic                  empty,
  input  logic                  pop,
  output logic [SAMPLE_W-1:0]   out_sample,
  output logic [FREQ_W-1:0]     out_freq_word,
  output logic                  out_in_delay,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_W-1:0]      cfg_wdata
);

  localparam int QW = $bits(lcsg_ctl_t) + PHASE_BITS;

  lcsg_cfg_t             cfg_r;
  logic                  take, wr_en, q_full, q_empty, q_pop;
  lcsg_ctl_t             wr_ctl, q_ctl;
  logic [PHASE_BITS-1:0] wr_phase, q_phase;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_freq    <= '0;
      cfg_r.half_step     <= '0;
      cfg_r.sweep_len     <= CFG_W'(1);
      cfg_r.phase_offset  <= '0;
      cfg_r.amplitude     <= '1;
      cfg_r.dc_offset     <= '0;
      cfg_r.initial_delay <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_addr))
        CFG_START_FREQ: cfg_r.start_freq    <= cfg_wdata[FREQ_W-1:0];
        CFG_HALF_STEP:  cfg_r.half_step     <= cfg_wdata[HALF_W-1:0];
        CFG_SWEEP_LEN:  cfg_r.sweep_len     <= cfg_wdata;
        CFG_PHASE_OFS:  cfg_r.phase_offset  <= cfg_wdata;
        CFG_AMPLITUDE:  cfg_r.amplitude     <= cfg_wdata[AMP_W-1:0];
        CFG_DC_OFFSET:  cfg_r.dc_offset     <= cfg_wdata[DC_W-1:0];
        CFG_INIT_DELAY: cfg_r.initial_delay <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  assign full = q_full;
  assign take = push && !q_full;

  lcsg_front #(
    .PHASE_BITS(PHASE_BITS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .take    (take),
    .tick    (in_tick),
    .cfg     (cfg_r),
    .wr_en   (wr_en),
    .wr_ctl  (wr_ctl),
    .wr_phase(wr_phase)
  );

  lcsg_queue #(
    .WIDTH(QW),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (wr_en),
    .wr_data({wr_ctl, wr_phase}),
    .rd_en  (q_pop),
    .rd_data({q_ctl, q_phase}),
    .full   (q_full),
    .empty  (q_empty)
  );

  lcsg_back #(
    .PHASE_BITS   (PHASE_BITS),
    .LUT_ADDR_BITS(LUT_ADDR_BITS),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .q_ctl    (q_ctl),
    .q_phase  (q_phase),
    .q_pop    (q_pop),
    .cfg      (cfg_r),
    .pop      (pop),
    .empty    (empty),
    .sample   (out_sample),
    .freq_word(out_freq_word),
    .in_delay (out_in_delay)
  );

endmodule

/* rtl/core/lcsg_checker.sv */
module lcsg_checker import lcsg_pkg::*; (
  input logic                clk,
  input logic                rst_n,
  input logic                full,
  input logic                empty,
  input logic                pop,
  input logic [SAMPLE_W-1:0] out_sample,
  input logic [FREQ_W-1:0]   out_freq_word,
  input logic                out_in_delay
);

  localparam logic [FREQ_W-1:0] FREQ_CAP = FREQ_W'(64'd1 << 30);

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> empty && !full)
    else $error("queue state not cleared by reset");

  a_delay_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && out_in_delay |-> out_sample == '0 && out_freq_word == '0)
    else $error("nonzero word during initial delay");

  a_freq_cap: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> out_freq_word <= FREQ_CAP)
    else $error("frequency word above clamp");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && !pop |=> !empty && $stable(out_sample) && $stable(out_freq_word)
                       && $stable(out_in_delay))
    else $error("stalled result word changed");

endmodule

bind linear_chirp_sine_generator lcsg_checker u_lcsg_checker (.*);
